// ----- sv/cpr_pkg.sv -----
// Package with the item types, configuration codes and datapath widths of the cubic resampler.
package cpr_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_FRAC_BITS = 16;

    localparam int T_BITS     = PHASE_FRAC_BITS + 2;
    localparam int PH_BITS    = PHASE_FRAC_BITS + 3;
    localparam int COEF_BITS  = SAMPLE_BITS + 4;
    localparam int Q_BITS     = SAMPLE_BITS + PHASE_FRAC_BITS + 12;
    localparam int HALF_BITS  = (Q_BITS + 1) / 2;
    localparam int PP_BITS    = HALF_BITS + T_BITS;
    localparam int ACC_BITS   = Q_BITS + T_BITS;
    localparam int SH_BITS    = Q_BITS - PHASE_FRAC_BITS - 1;

    localparam int MAX_RESULTS   = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = T_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_RATIO = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BYPASS     = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] STEP_RATIO_RESET =
        CFG_DATA_BITS'(1) << PHASE_FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_sample;
        logic                          last_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic                          last_in_run;
    } t_out_item;

endpackage

// ----- sv/cubic_pitch_resampler.sv -----
// Top level of the cubic resampler: window, phase, sequencer and shared multiplier datapath.
// Bypass: the result is valid the cycle after its item is accepted; ready while output is free.
// A sample that leaves fewer than four in the buffer: ready again the cycle after accept.
// Otherwise each result takes three Horner steps on the shared multiplier, plus phase,
// magnitude and rounding steps; ready stays low while n results (0 to 4) are made.
// Reset is synchronous, active low; window, phase, count clear; step 1.0 and bypass on.
module cubic_pitch_resampler
    import cpr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_item,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ABS,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_NEXT,
        S_RND
    } t_state;

    localparam logic [PH_BITS-1:0]  PH_ONE   = PH_BITS'(1) << PHASE_FRAC_BITS;
    localparam logic [ACC_BITS-1:0] RND_BIAS =
        (ACC_BITS'(1) << PHASE_FRAC_BITS) - ACC_BITS'(1);
    localparam logic [SH_BITS-1:0]  SAT_NEG_MAG = SH_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [SH_BITS-1:0]  SAT_POS_MAG = SAT_NEG_MAG - SH_BITS'(1);
    localparam logic [SAMPLE_BITS-1:0] SAT_POS = SAT_POS_MAG[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] SAT_NEG = SAT_NEG_MAG[SAMPLE_BITS-1:0];
    localparam logic [2:0] N_LIMIT = 3'(MAX_RESULTS);
    localparam logic [1:0] STEP_LAST = 2'd3;

    t_state                        r_state;
    logic [T_BITS-1:0]             r_step_ratio;
    logic                          r_bypass;
    logic signed [SAMPLE_BITS-1:0] r_hist [3];
    logic [PHASE_FRAC_BITS-1:0]    r_phase;
    logic [1:0]                    r_fill;
    logic                          r_last_in;
    logic signed [COEF_BITS-1:0]   r_coef_a;
    logic signed [COEF_BITS-1:0]   r_coef_b;
    logic signed [COEF_BITS-1:0]   r_coef_c;
    logic signed [COEF_BITS-1:0]   r_coef_d;
    logic [PH_BITS-1:0]            r_ph;
    logic [T_BITS-1:0]             r_t;
    logic [2:0]                    r_n;
    logic [1:0]                    r_step;
    logic                          r_last_res;
    logic signed [Q_BITS-1:0]      r_q;
    logic [Q_BITS-1:0]             r_mag;
    logic                          r_neg;
    logic [PP_BITS-1:0]            r_pp;
    logic [ACC_BITS-1:0]           r_acc;
    logic                          r_out_valid;
    t_out_item                     r_out_item;

    logic                          w_out_free;
    logic                          w_out_load;
    logic                          w_in_acc;
    logic signed [COEF_BITS-1:0]   w_y0, w_y1, w_y2, w_y3;
    logic signed [COEF_BITS-1:0]   w_a, w_b, w_c, w_d;
    logic [PH_BITS-1:0]            w_ph_sub;
    logic [HALF_BITS-1:0]          w_mul_a;
    logic [PP_BITS-1:0]            w_mul_p;
    logic [Q_BITS-1:0]             w_fl;
    logic signed [COEF_BITS-1:0]   w_coef;
    logic signed [Q_BITS-1:0]      w_coef_ext;
    logic signed [Q_BITS-1:0]      w_a_ext;
    logic signed [Q_BITS-1:0]      w_qn;
    logic [SH_BITS-1:0]            w_sh;
    logic [SAMPLE_BITS-1:0]        w_sat;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_bypass || w_out_free);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (w_in_acc && r_bypass) || ((r_state == S_RND) && w_out_free);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_y0 = COEF_BITS'(r_hist[0]);
    assign w_y1 = COEF_BITS'(r_hist[1]);
    assign w_y2 = COEF_BITS'(r_hist[2]);
    assign w_y3 = COEF_BITS'(i_in_item.in_sample);

    assign w_a = w_y3 - w_y0 + (w_y1 <<< 1) + w_y1 - (w_y2 <<< 1) - w_y2;
    assign w_b = (w_y0 <<< 1) - (w_y1 <<< 2) - w_y1 + (w_y2 <<< 2) - w_y3;
    assign w_c = w_y2 - w_y0;
    assign w_d = w_y1 <<< 1;

    assign w_ph_sub = r_ph - PH_ONE;

    assign w_mul_a = (r_state == S_MUL_LO) ? r_mag[HALF_BITS-1:0]
                                           : HALF_BITS'(r_mag[Q_BITS-1:HALF_BITS]);
    assign w_mul_p = PP_BITS'(w_mul_a) * PP_BITS'(r_t);

    always_comb begin
        unique case (r_step)
            2'd0:    w_coef = r_coef_b;
            2'd1:    w_coef = r_coef_c;
            default: w_coef = r_coef_d;
        endcase
    end

    assign w_coef_ext = Q_BITS'(w_coef);
    assign w_a_ext    = Q_BITS'(r_coef_a);
    assign w_fl       = Q_BITS'(r_acc >> PHASE_FRAC_BITS);
    assign w_qn       = $signed(r_neg ? (Q_BITS'(0) - w_fl) : w_fl)
                        + (w_coef_ext <<< PHASE_FRAC_BITS);
    assign w_sh       = SH_BITS'(r_mag >> (PHASE_FRAC_BITS + 1));

    always_comb begin
        if (r_neg) begin
            w_sat = (w_sh > SAT_NEG_MAG) ? SAT_NEG
                                         : SAMPLE_BITS'(0) - w_sh[SAMPLE_BITS-1:0];
        end else begin
            w_sat = (w_sh > SAT_POS_MAG) ? SAT_POS : w_sh[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step_ratio <= STEP_RATIO_RESET;
            r_bypass     <= 1'b1;
            r_hist[0]    <= '0;
            r_hist[1]    <= '0;
            r_hist[2]    <= '0;
            r_phase      <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
            r_n          <= '0;
            r_step       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_STEP_RATIO) begin
                    r_step_ratio <= i_cfg_data;
                end else if (i_cfg_index == CFG_BYPASS) begin
                    r_bypass <= i_cfg_data[0];
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_bypass) begin
                            r_out_item.out_sample  <= i_in_item.in_sample;
                            r_out_item.last_in_run <= 1'b1;
                        end else begin
                            r_coef_a  <= w_a;
                            r_coef_b  <= w_b;
                            r_coef_c  <= w_c;
                            r_coef_d  <= w_d;
                            r_last_in <= i_in_item.last_of_buffer;
                            r_n       <= '0;
                            if (i_in_item.last_of_buffer) begin
                                r_hist[0] <= '0;
                                r_hist[1] <= '0;
                                r_hist[2] <= '0;
                                r_fill    <= '0;
                            end else begin
                                r_hist[0] <= r_hist[1];
                                r_hist[1] <= r_hist[2];
                                r_hist[2] <= i_in_item.in_sample;
                                if (r_fill != 2'd3) begin
                                    r_fill <= r_fill + 2'd1;
                                end
                            end
                            if (r_fill == 2'd3) begin
                                r_ph    <= PH_BITS'(r_phase) + PH_BITS'(r_step_ratio);
                                r_state <= S_CHECK;
                            end else if (i_in_item.last_of_buffer) begin
                                r_phase <= '0;
                            end
                        end
                    end
                end
                S_CHECK: begin
                    if (r_ph >= PH_ONE && r_n != N_LIMIT) begin
                        r_ph       <= w_ph_sub;
                        r_t        <= w_ph_sub[T_BITS-1:0];
                        r_last_res <= (w_ph_sub < PH_ONE) || (r_n == N_LIMIT - 3'd1);
                        r_q        <= w_a_ext <<< PHASE_FRAC_BITS;
                        r_step     <= '0;
                        r_state    <= S_ABS;
                    end else begin
                        r_phase <= r_last_in ? '0 : r_ph[PHASE_FRAC_BITS-1:0];
                        r_state <= S_IDLE;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_q[Q_BITS-1];
                    r_mag   <= r_q[Q_BITS-1] ? Q_BITS'(0) - Q_BITS'(r_q) : Q_BITS'(r_q);
                    r_state <= (r_step == STEP_LAST) ? S_RND : S_MUL_LO;
                end
                S_MUL_LO: begin
                    r_pp    <= w_mul_p;
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_acc   <= ACC_BITS'(r_pp) + (r_neg ? RND_BIAS : '0);
                    r_pp    <= w_mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc + (ACC_BITS'(r_pp) << HALF_BITS);
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_q     <= w_qn;
                    r_step  <= r_step + 2'd1;
                    r_state <= S_ABS;
                end
                S_RND: begin
                    if (w_out_free) begin
                        r_out_item.out_sample  <= w_sat;
                        r_out_item.last_in_run <= r_last_res;
                        r_n                    <= r_n + 3'd1;
                        r_state                <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_bypass_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_bypass) |=> (o_out_valid && o_out_item.last_in_run))
        else $error("bypassed item did not reach the output as a final result");

    a_full_window_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !r_bypass && r_fill == 2'd3) |=> (r_state == S_CHECK && !o_in_ready))
        else $error("item with full window did not start the phase loop");

    a_more_results_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last_in_run) |-> (r_state != S_IDLE))
        else $error("non-final result shown while sequencer is idle");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_LO || r_state == S_NEXT) |-> (r_step != STEP_LAST))
        else $error("Horner step counter ran past the last coefficient");

endmodule
